// ===== rtl/mrs_pkg.sv =====
// Package for the Modbus RTU slave responder: beat structs, operation,
// function and register index codes, limits and the CRC-16 byte step.
// No dependencies.
`default_nettype none

package mrs_pkg;

    // Sizing defaults
    localparam int HOLDING_COUNT_DEF = 20;
    localparam int INPUT_COUNT_DEF   = 40;
    localparam int FRAME_LIMIT_DEF   = 250;
    localparam int MAX_RESULTS       = 43;

    // Reset values of the configuration registers
    localparam logic [7:0] GAP_LIMIT_RST  = 8'd20;
    localparam logic [7:0] SLAVE_ADDR_RST = 8'd10;

    // Configuration register indexes
    localparam logic [0:0] CFG_GAP_LIMIT  = 1'b0;
    localparam logic [0:0] CFG_SLAVE_ADDR = 1'b1;

    // Input operations
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_ERROR = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_LOCAL = 2'd3;

    // Function and exception codes
    localparam logic [7:0] FN_READ_HOLDING = 8'h03;
    localparam logic [7:0] FN_READ_INPUT   = 8'h04;
    localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;
    localparam logic [7:0] FN_EXC_FLAG     = 8'h80;
    localparam logic [7:0] EXC_BAD_FUNC    = 8'h01;
    localparam logic [7:0] EXC_BAD_RANGE   = 8'h02;

    // Special holding registers
    localparam logic [6:0] REG_ID        = 7'd100;
    localparam logic [6:0] REG_WIDE_LO   = 7'd6;
    localparam logic [6:0] REG_MIRROR_LO = 7'd9;
    localparam logic [6:0] REG_CAL_HI    = 7'd10;
    localparam logic [6:0] REG_EVENT_END = 7'd12;

    localparam logic [15:0] CRC_INIT = 16'hffff;
    localparam logic [15:0] CRC_POLY = 16'ha001;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  rx_byte;
        logic [5:0]  table_index;
        logic [15:0] table_value;
    } t_in;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_first_byte;
        logic [7:0]  tx_second_byte;
        logic        tx_pair;
        logic        write_valid;
        logic [6:0]  write_register;
        logic [15:0] write_data;
        logic        calibration_request;
        logic        last;
    } t_out;

    // One byte of the reflected CRC-16
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int n = 0; n < 8; n++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/modbus_rtu_slave_responder_core.sv =====
// Modbus RTU slave responder top level: frame buffer memory, register
// table memory and the decode sequencer. Depends on mrs_pkg.
//
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_ready   | i_in  (mrs_pkg::t_in)
// out     | output    | o_out_valid / i_out_ready | o_out (mrs_pkg::t_out)
// cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// A byte, error, local write or non-closing tick is taken in the idle state.
// A closing tick on a frame of four bytes or more starts the decode
// sequencer: a CRC scan through the frame buffer port, two buffer reads per
// write-multiple event, an event for a single write, then the response bytes
// (the high byte of a table word waits on a table read).
// o_in_ready is low while the sequencer runs; the out stage stalls it.
// Reset is synchronous; table entries read as zero until written.
`default_nettype none

module modbus_rtu_slave_responder_core #(
    parameter int HOLDING_COUNT = mrs_pkg::HOLDING_COUNT_DEF,
    parameter int INPUT_COUNT   = mrs_pkg::INPUT_COUNT_DEF,
    parameter int FRAME_LIMIT   = mrs_pkg::FRAME_LIMIT_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire mrs_pkg::t_in i_in,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output mrs_pkg::t_out     o_out,
    input  wire logic         i_cfg_we,
    input  wire logic [0:0]   i_cfg_index,
    input  wire logic [7:0]   i_cfg_data
);

    localparam int TABLE_SIZE = HOLDING_COUNT + INPUT_COUNT;
    localparam int TW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_CRC_WAIT, S_CRC_DATA, S_DISPATCH, S_WR_NEXT, S_WR_WAIT,
        S_WR_DATA, S_EVENT, S_TX, S_TX_WAIT, S_TX_DATA, S_CRC_LO, S_CRC_HI
    } t_state;

    t_state r_state, n_state;
    logic [7:0]  r_gap_limit, n_gap_limit;
    logic [7:0]  r_slave, n_slave;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_gap_cnt, n_gap_cnt;
    logic        r_gap_run, n_gap_run;
    logic        r_line_err, n_line_err;
    logic [7:0]  r_dlen, n_dlen;
    logic [7:0]  r_ptr, n_ptr;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_hdr [6];
    logic [7:0]  n_hdr [6];
    logic [7:0]  r_txh [6];
    logic [7:0]  n_txh [6];
    logic [7:0]  r_tx_n, n_tx_n;
    logic [7:0]  r_tx_k, n_tx_k;
    logic        r_half, n_half;
    logic [7:0]  r_half_b, n_half_b;
    logic [15:0] r_word, n_word;
    logic        r_word_ok, n_word_ok;
    logic        r_read, n_read;
    logic        r_multi, n_multi;
    logic [6:0]  r_wr_reg, n_wr_reg;
    logic [6:0]  r_wr_left, n_wr_left;
    logic [7:0]  r_ev_hi, n_ev_hi;
    logic [7:0]  r_ev_lo, n_ev_lo;
    logic [TW-1:0] r_tab_ptr, n_tab_ptr;
    logic [5:0]  r_items, n_items;
    mrs_pkg::t_out r_out, n_out;
    logic        r_out_valid, n_out_valid;

    // Memories and their ports
    logic [7:0]  fb_mem [256];
    logic [7:0]  r_fb_q;
    logic        fb_we;
    logic [15:0] tab_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_tab_valid;
    logic [15:0] r_tab_q;
    logic        r_tab_vq;
    logic        tab_we;
    logic [TW-1:0] tab_wa;
    logic [15:0] tab_wd;

    // Combinational helpers
    logic        in_fire, out_free;
    logic        emit;
    mrs_pkg::t_out e_item;
    logic [7:0]  payload;
    logic [7:0]  gap_inc;
    logic [15:0] start16, count16;
    logic [16:0] sum17;
    logic [7:0]  fn;
    logic [7:0]  rd_b;
    logic        word_byte;
    logic [7:0]  m_k;
    logic [7:0]  tx_b;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign payload     = r_dlen - 8'd2;
    assign start16     = {r_hdr[2], r_hdr[3]};
    assign count16     = {r_hdr[4], r_hdr[5]};
    assign sum17       = {1'b0, start16} + {1'b0, count16};
    assign fn          = r_hdr[1];
    assign rd_b        = (r_ptr < payload) ? r_fb_q : 8'h00;
    assign word_byte   = r_read && (r_tx_k >= 8'd3);
    assign m_k         = r_tx_k - 8'd3;
    assign tx_b        = word_byte ? (m_k[0] ? r_word[7:0] : r_word[15:8])
                                   : r_txh[r_tx_k[2:0]];

    // Next-state and datapath logic
    always_comb begin
        n_state = r_state; n_gap_limit = r_gap_limit; n_slave = r_slave;
        n_len = r_len; n_gap_cnt = r_gap_cnt; n_gap_run = r_gap_run;
        n_line_err = r_line_err; n_dlen = r_dlen; n_ptr = r_ptr; n_crc = r_crc;
        n_hdr = r_hdr; n_txh = r_txh; n_tx_n = r_tx_n; n_tx_k = r_tx_k;
        n_half = r_half; n_half_b = r_half_b; n_word = r_word;
        n_word_ok = r_word_ok; n_read = r_read; n_multi = r_multi;
        n_wr_reg = r_wr_reg; n_wr_left = r_wr_left; n_ev_hi = r_ev_hi;
        n_ev_lo = r_ev_lo; n_tab_ptr = r_tab_ptr; n_items = r_items;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        fb_we = 1'b0;
        tab_we = 1'b0;
        tab_wa = TW'(i_in.table_index);
        tab_wd = i_in.table_value;
        emit = 1'b0;
        e_item = '0;
        gap_inc = (r_gap_cnt != 8'hff) ? r_gap_cnt + 8'd1 : r_gap_cnt;

        // Take configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                mrs_pkg::CFG_GAP_LIMIT:  n_gap_limit = i_cfg_data;
                mrs_pkg::CFG_SLAVE_ADDR: n_slave = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in.op)
                        mrs_pkg::OP_BYTE: begin
                            fb_we = 1'b1;
                            if (int'(r_len) < FRAME_LIMIT) n_len = r_len + 8'd1;
                            n_gap_cnt = 8'd0;
                            n_gap_run = 1'b1;
                        end
                        mrs_pkg::OP_ERROR: begin
                            n_line_err = 1'b1;
                            n_gap_cnt = 8'd0;
                            n_gap_run = 1'b1;
                        end
                        mrs_pkg::OP_TICK: begin
                            if (r_line_err) begin
                                n_line_err = 1'b0;
                                n_gap_run = 1'b0;
                                n_gap_cnt = 8'd0;
                                n_len = 8'd0;
                            end else if (r_gap_run) begin
                                n_gap_cnt = gap_inc;
                                if (gap_inc >= r_gap_limit) begin
                                    // Close the frame and, if it holds four bytes or more, start the scan
                                    n_gap_run = 1'b0;
                                    n_gap_cnt = 8'd0;
                                    n_len = 8'd0;
                                    n_dlen = r_len;
                                    n_items = 6'd0;
                                    if (r_len >= 8'd4) begin
                                        n_ptr = 8'd0;
                                        n_crc = mrs_pkg::CRC_INIT;
                                        for (int i = 0; i < 6; i++) n_hdr[i] = 8'h00;
                                        n_state = S_CRC_WAIT;
                                    end
                                end
                            end
                        end
                        default: begin
                            if (int'(i_in.table_index) < TABLE_SIZE) tab_we = 1'b1;
                        end
                    endcase
                end
            end
            S_CRC_WAIT: n_state = S_CRC_DATA;
            S_CRC_DATA: begin
                if (r_ptr < payload) begin
                    n_crc = mrs_pkg::crc_step(r_crc, r_fb_q);
                    if (r_ptr < 8'd6) n_hdr[r_ptr[2:0]] = r_fb_q;
                    n_ptr = r_ptr + 8'd1;
                    n_state = S_CRC_WAIT;
                end else if (r_ptr == payload) begin
                    n_ptr = r_ptr + 8'd1;
                    n_state = (r_fb_q == r_crc[7:0]) ? S_CRC_WAIT : S_IDLE;
                end else begin
                    n_state = (r_fb_q == r_crc[15:8]) ? S_DISPATCH : S_IDLE;
                end
            end
            S_DISPATCH: begin
                n_tx_k = 8'd0;
                n_crc = mrs_pkg::CRC_INIT;
                n_half = 1'b0;
                n_word_ok = 1'b0;
                n_read = 1'b0;
                n_multi = 1'b0;
                n_txh[0] = r_slave;
                n_txh[1] = fn | mrs_pkg::FN_EXC_FLAG;
                n_txh[2] = mrs_pkg::EXC_BAD_RANGE;
                n_txh[3] = 8'h00;
                n_txh[4] = 8'h00;
                n_txh[5] = 8'h00;
                n_tx_n = 8'd3;
                n_state = S_TX;
                if (r_hdr[0] != r_slave) begin
                    n_state = S_IDLE;
                end else if (fn == mrs_pkg::FN_READ_HOLDING
                             || fn == mrs_pkg::FN_READ_INPUT) begin
                    if (sum17 <= ((fn == mrs_pkg::FN_READ_HOLDING)
                                  ? 17'(HOLDING_COUNT) : 17'(INPUT_COUNT))) begin
                        n_read = 1'b1;
                        n_txh[1] = fn;
                        n_txh[2] = {r_hdr[5][6:0], 1'b0};
                        n_tx_n = 8'd3 + {r_hdr[5][6:0], 1'b0};
                        n_tab_ptr = (fn == mrs_pkg::FN_READ_HOLDING)
                                    ? TW'(start16) : TW'(start16 + 16'(HOLDING_COUNT));
                    end
                end else if (fn == mrs_pkg::FN_WRITE_MULTI) begin
                    if (sum17 <= 17'(HOLDING_COUNT)) begin
                        n_txh[1] = mrs_pkg::FN_WRITE_MULTI;
                        n_txh[2] = r_hdr[2];
                        n_txh[3] = r_hdr[3];
                        n_txh[4] = r_hdr[4];
                        n_txh[5] = r_hdr[5];
                        n_tx_n = 8'd6;
                        n_multi = 1'b1;
                        n_wr_reg = start16[6:0];
                        n_wr_left = count16[6:0];
                        n_ptr = 8'd7;
                        n_state = S_WR_NEXT;
                    end
                end else if (fn == mrs_pkg::FN_WRITE_SINGLE) begin
                    if (start16 < 16'(HOLDING_COUNT) || start16 == 16'(mrs_pkg::REG_ID)) begin
                        for (int i = 0; i < 6; i++) n_txh[i] = r_hdr[i];
                        n_tx_n = 8'd6;
                        n_wr_reg = start16[6:0];
                        n_ev_hi = r_hdr[4];
                        n_ev_lo = r_hdr[5];
                        if (start16 == 16'(mrs_pkg::REG_ID)) begin
                            n_slave = r_hdr[5];
                            n_state = S_EVENT;
                        end else if (start16 < 16'(mrs_pkg::REG_EVENT_END)) begin
                            n_state = S_EVENT;
                        end
                    end
                end else begin
                    n_txh[2] = mrs_pkg::EXC_BAD_FUNC;
                end
            end
            S_WR_NEXT: begin
                if (r_wr_left == 7'd0 || r_wr_reg >= mrs_pkg::REG_EVENT_END) begin
                    n_state = S_TX;
                end else begin
                    n_state = S_WR_WAIT;
                end
            end
            S_WR_WAIT: n_state = S_WR_DATA;
            S_WR_DATA: begin
                n_ptr = r_ptr + 8'd1;
                if (r_ptr[0]) begin
                    n_ev_hi = rd_b;
                    n_state = S_WR_WAIT;
                end else begin
                    n_ev_lo = rd_b;
                    n_state = S_EVENT;
                end
            end
            S_EVENT: begin
                if (out_free) begin
                    emit = 1'b1;
                    e_item.write_valid = 1'b1;
                    e_item.write_register = r_wr_reg;
                    if (r_wr_reg < mrs_pkg::REG_WIDE_LO || r_wr_reg == mrs_pkg::REG_ID) begin
                        e_item.write_data = {8'h00, r_ev_lo};
                    end else begin
                        e_item.write_data = {r_ev_hi, r_ev_lo};
                    end
                    e_item.calibration_request = (r_wr_reg == mrs_pkg::REG_MIRROR_LO)
                                                 || (r_wr_reg == mrs_pkg::REG_CAL_HI);
                    // Mirror the calibration group into the readback table
                    if (r_wr_reg >= mrs_pkg::REG_MIRROR_LO
                        && r_wr_reg < mrs_pkg::REG_EVENT_END
                        && int'(r_wr_reg) < TABLE_SIZE) begin
                        tab_we = 1'b1;
                        tab_wa = TW'(r_wr_reg);
                        tab_wd = {r_ev_hi, r_ev_lo};
                    end
                    if (r_multi) begin
                        n_wr_reg = r_wr_reg + 7'd1;
                        n_wr_left = r_wr_left - 7'd1;
                        n_state = S_WR_NEXT;
                    end else begin
                        n_state = S_TX;
                    end
                end
            end
            S_TX: begin
                if (r_tx_k == r_tx_n) begin
                    n_state = S_CRC_LO;
                end else if (word_byte && !m_k[0] && !r_word_ok) begin
                    n_state = S_TX_WAIT;
                end else if (out_free) begin
                    n_crc = mrs_pkg::crc_step(r_crc, tx_b);
                    n_tx_k = r_tx_k + 8'd1;
                    if (word_byte && m_k[0]) begin
                        n_word_ok = 1'b0;
                        n_tab_ptr = r_tab_ptr + TW'(1);
                    end
                    if (!r_half) begin
                        n_half = 1'b1;
                        n_half_b = tx_b;
                    end else begin
                        emit = 1'b1;
                        e_item.tx_valid = 1'b1;
                        e_item.tx_first_byte = r_half_b;
                        e_item.tx_second_byte = tx_b;
                        e_item.tx_pair = 1'b1;
                        n_half = 1'b0;
                    end
                end
            end
            S_TX_WAIT: n_state = S_TX_DATA;
            S_TX_DATA: begin
                n_word = r_tab_vq ? r_tab_q : 16'h0000;
                n_word_ok = 1'b1;
                n_state = S_TX;
            end
            S_CRC_LO: begin
                if (out_free) begin
                    n_state = S_CRC_HI;
                    if (!r_half) begin
                        n_half = 1'b1;
                        n_half_b = r_crc[7:0];
                    end else begin
                        emit = 1'b1;
                        e_item.tx_valid = 1'b1;
                        e_item.tx_first_byte = r_half_b;
                        e_item.tx_second_byte = r_crc[7:0];
                        e_item.tx_pair = 1'b1;
                        n_half = 1'b0;
                    end
                end
            end
            S_CRC_HI: begin
                if (out_free) begin
                    emit = 1'b1;
                    e_item.tx_valid = 1'b1;
                    e_item.last = 1'b1;
                    if (r_half) begin
                        e_item.tx_first_byte = r_half_b;
                        e_item.tx_second_byte = r_crc[15:8];
                        e_item.tx_pair = 1'b1;
                    end else begin
                        e_item.tx_first_byte = r_crc[15:8];
                    end
                    n_half = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Load the out stage; stop at the item cap
        if (emit) begin
            n_out = e_item;
            n_out_valid = 1'b1;
            n_items = r_items + 6'd1;
            if (int'(r_items) == mrs_pkg::MAX_RESULTS - 1) begin
                n_out.last = 1'b1;
                n_half = 1'b0;
                n_state = S_IDLE;
            end
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gap_limit <= mrs_pkg::GAP_LIMIT_RST;
            r_slave     <= mrs_pkg::SLAVE_ADDR_RST;
            r_len       <= 8'd0;
            r_gap_cnt   <= 8'd0;
            r_gap_run   <= 1'b0;
            r_line_err  <= 1'b0;
            r_half      <= 1'b0;
            r_word_ok   <= 1'b0;
            r_items     <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gap_limit <= n_gap_limit;
            r_slave     <= n_slave;
            r_len       <= n_len;
            r_gap_cnt   <= n_gap_cnt;
            r_gap_run   <= n_gap_run;
            r_line_err  <= n_line_err;
            r_half      <= n_half;
            r_word_ok   <= n_word_ok;
            r_items     <= n_items;
            r_out_valid <= n_out_valid;
        end
        r_dlen    <= n_dlen;
        r_ptr     <= n_ptr;
        r_crc     <= n_crc;
        r_hdr     <= n_hdr;
        r_txh     <= n_txh;
        r_tx_n    <= n_tx_n;
        r_tx_k    <= n_tx_k;
        r_half_b  <= n_half_b;
        r_word    <= n_word;
        r_read    <= n_read;
        r_multi   <= n_multi;
        r_wr_reg  <= n_wr_reg;
        r_wr_left <= n_wr_left;
        r_ev_hi   <= n_ev_hi;
        r_ev_lo   <= n_ev_lo;
        r_tab_ptr <= n_tab_ptr;
        r_out     <= n_out;
    end

    // Frame buffer: write at the fill point, read at the scan pointer
    always_ff @(posedge i_clk) begin
        if (fb_we) fb_mem[r_len] <= i_in.rx_byte;
        r_fb_q <= fb_mem[r_ptr];
    end

    // Register table: entries read as zero until written
    always_ff @(posedge i_clk) begin
        if (tab_we) tab_mem[tab_wa] <= tab_wd;
        r_tab_q <= tab_mem[r_tab_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_valid <= '0;
            r_tab_vq    <= 1'b0;
        end else begin
            if (tab_we) r_tab_valid[tab_wa] <= 1'b1;
            r_tab_vq <= r_tab_valid[r_tab_ptr];
        end
    end

    // Checks on the sequencer
    a_idle_no_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_half)
        else $error("half-filled byte pair left behind in idle");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_len) <= FRAME_LIMIT)
        else $error("frame length beyond limit");

    a_tx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TX || r_state == S_TX_WAIT || r_state == S_TX_DATA)
        |-> (r_tx_k <= r_tx_n))
        else $error("response byte index past end");

    a_kind_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.tx_valid && r_out.write_valid))
        else $error("beat marked both response and write event");

endmodule

`default_nettype wire

// ===== tb/tb_modbus_rtu_slave_responder_core.sv =====
// Testbench for the Modbus RTU slave responder core: directed and random request
// frames, checked beat by beat against a local response predictor.
// Depends on mrs_pkg and modbus_rtu_slave_responder_core.
`default_nettype none

module tb_modbus_rtu_slave_responder_core;

    localparam int HOLD_N   = mrs_pkg::HOLDING_COUNT_DEF;
    localparam int INPUT_N  = mrs_pkg::INPUT_COUNT_DEF;
    localparam int TABLE_N  = HOLD_N + INPUT_N;
    localparam int FRM_MAX  = mrs_pkg::FRAME_LIMIT_DEF;
    localparam int SETTLE   = 1500;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    mrs_pkg::t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    mrs_pkg::t_out o_out;
    logic i_cfg_we;
    logic [0:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    modbus_rtu_slave_responder_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Predicted slave state
    logic [7:0]  frm_buf [256];
    int          frm_len;
    int          gap_cnt;
    bit          gap_run;
    bit          line_err;
    logic [7:0]  slave_id;
    logic [15:0] reg_tab [TABLE_N];
    logic [7:0]  gap_lim;

    mrs_pkg::t_out resp_q [$];
    mrs_pkg::t_out step_q [$];
    logic [7:0]  tx_bytes [$];
    int          err_cnt;
    int          send_idle_pct;
    int          stall_pct;
    int          rand_items;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int n = 0; n < 8; n++) begin
            if (c[0]) c = (c >> 1) ^ 16'ha001;
            else c = c >> 1;
        end
        return c;
    endfunction

    function automatic void emit(bit tv, logic [7:0] b1, logic [7:0] b2, bit pair, bit wv,
                                 logic [6:0] rg, logic [15:0] data, bit cal);
        mrs_pkg::t_out r;
        if (step_q.size() >= mrs_pkg::MAX_RESULTS) return;
        r.tx_valid = tv;
        r.tx_first_byte = b1;
        r.tx_second_byte = b2;
        r.tx_pair = pair;
        r.write_valid = wv;
        r.write_register = rg;
        r.write_data = data;
        r.calibration_request = cal;
        r.last = 1'b0;
        step_q.push_back(r);
    endfunction

    // Append CRC to the pending response and split it into byte pairs
    function automatic void emit_response();
        logic [15:0] crc;
        crc = 16'hffff;
        foreach (tx_bytes[i]) crc = crc16_next(crc, tx_bytes[i]);
        tx_bytes.push_back(crc[7:0]);
        tx_bytes.push_back(crc[15:8]);
        for (int i = 0; i < tx_bytes.size(); i += 2) begin
            if (i + 1 < tx_bytes.size())
                emit(1, tx_bytes[i], tx_bytes[i+1], 1, 0, 0, 0, 0);
            else
                emit(1, tx_bytes[i], 8'h00, 0, 0, 0, 0, 0);
        end
    endfunction

    function automatic void emit_exception(logic [7:0] fn, logic [7:0] code);
        tx_bytes = {slave_id, fn | mrs_pkg::FN_EXC_FLAG, code};
        emit_response();
    endfunction

    function automatic void master_write(int rg, logic [7:0] hi, logic [7:0] lo);
        if (rg < mrs_pkg::REG_WIDE_LO) begin
            emit(0, 0, 0, 0, 1, rg[6:0], {8'h00, lo}, 0);
        end else if (rg < mrs_pkg::REG_EVENT_END) begin
            if (rg >= mrs_pkg::REG_MIRROR_LO) reg_tab[rg] = {hi, lo};
            emit(0, 0, 0, 0, 1, rg[6:0], {hi, lo},
                 (rg == mrs_pkg::REG_MIRROR_LO || rg == mrs_pkg::REG_CAL_HI));
        end
    endfunction

    function automatic logic [7:0] req_at(int i, int payload);
        return (i < payload) ? frm_buf[i] : 8'h00;
    endfunction

    // Validate and answer a closed request frame
    function automatic void answer_frame();
        int payload, start, cnt, lim, base, idx;
        logic [15:0] crc, v;
        logic [7:0] fn, hi, lo;
        if (frm_len < 4) return;
        payload = frm_len - 2;
        crc = 16'hffff;
        for (int i = 0; i < payload; i++) crc = crc16_next(crc, frm_buf[i]);
        if (frm_buf[payload] != crc[7:0] || frm_buf[payload+1] != crc[15:8]) return;
        if (frm_buf[0] != slave_id) return;
        fn = req_at(1, payload);
        start = {req_at(2, payload), req_at(3, payload)};
        cnt = {req_at(4, payload), req_at(5, payload)};
        if (fn == mrs_pkg::FN_READ_HOLDING || fn == mrs_pkg::FN_READ_INPUT) begin
            lim = (fn == mrs_pkg::FN_READ_HOLDING) ? HOLD_N : INPUT_N;
            base = (fn == mrs_pkg::FN_READ_HOLDING) ? 0 : HOLD_N;
            if (start + cnt > lim) begin
                emit_exception(fn, mrs_pkg::EXC_BAD_RANGE);
                return;
            end
            tx_bytes = {slave_id, fn, 8'((cnt << 1) & 8'hff)};
            for (int i = 0; i < cnt; i++) begin
                idx = base + start + i;
                v = (idx < TABLE_N) ? reg_tab[idx] : 16'h0000;
                tx_bytes.push_back(v[15:8]);
                tx_bytes.push_back(v[7:0]);
            end
            emit_response();
        end else if (fn == mrs_pkg::FN_WRITE_MULTI) begin
            if (start + cnt > HOLD_N) begin
                emit_exception(fn, mrs_pkg::EXC_BAD_RANGE);
                return;
            end
            for (int i = 0; i < cnt; i++)
                master_write(start + i, req_at(7 + 2*i, payload), req_at(8 + 2*i, payload));
            tx_bytes = {slave_id, mrs_pkg::FN_WRITE_MULTI, 8'(start >> 8), 8'(start),
                        8'(cnt >> 8), 8'(cnt)};
            emit_response();
        end else if (fn == mrs_pkg::FN_WRITE_SINGLE) begin
            hi = req_at(4, payload);
            lo = req_at(5, payload);
            if (start < HOLD_N) begin
                master_write(start, hi, lo);
            end else if (start == mrs_pkg::REG_ID) begin
                emit(0, 0, 0, 0, 1, mrs_pkg::REG_ID, {8'h00, lo}, 0);
            end else begin
                emit_exception(fn, mrs_pkg::EXC_BAD_RANGE);
                return;
            end
            tx_bytes.delete();
            for (int i = 0; i < 6; i++) tx_bytes.push_back(req_at(i, payload));
            if (start == mrs_pkg::REG_ID) slave_id = lo;
            emit_response();
        end else begin
            emit_exception(fn, mrs_pkg::EXC_BAD_FUNC);
        end
    endfunction

    // Advance the predicted state by one accepted input beat
    function automatic void predict_beat(mrs_pkg::t_in it);
        step_q.delete();
        tx_bytes.delete();
        case (it.op)
            mrs_pkg::OP_BYTE: begin
                frm_buf[frm_len] = it.rx_byte;
                if (frm_len < FRM_MAX) frm_len++;
                gap_cnt = 0;
                gap_run = 1;
            end
            mrs_pkg::OP_ERROR: begin
                line_err = 1;
                gap_cnt = 0;
                gap_run = 1;
            end
            mrs_pkg::OP_TICK: begin
                if (line_err) begin
                    line_err = 0;
                    gap_run = 0;
                    gap_cnt = 0;
                    frm_len = 0;
                end else if (gap_run) begin
                    if (gap_cnt < 255) gap_cnt++;
                    if (gap_cnt >= gap_lim) begin
                        gap_run = 0;
                        gap_cnt = 0;
                        answer_frame();
                        frm_len = 0;
                    end
                end
            end
            default: begin
                if (it.table_index < TABLE_N) reg_tab[it.table_index] = it.table_value;
            end
        endcase
        if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
        foreach (step_q[i]) resp_q.push_back(step_q[i]);
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    // Check each output beat against the oldest prediction
    always @(posedge i_clk) begin
        mrs_pkg::t_out e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (resp_q.size() == 0) begin
                report("unexpected beat", 1, 0);
            end else begin
                e = resp_q.pop_front();
                if (o_out.tx_valid !== e.tx_valid) report("tx_valid", o_out.tx_valid, e.tx_valid);
                if (o_out.tx_first_byte !== e.tx_first_byte)
                    report("tx_first_byte", o_out.tx_first_byte, e.tx_first_byte);
                if (o_out.tx_second_byte !== e.tx_second_byte)
                    report("tx_second_byte", o_out.tx_second_byte, e.tx_second_byte);
                if (o_out.tx_pair !== e.tx_pair) report("tx_pair", o_out.tx_pair, e.tx_pair);
                if (o_out.write_valid !== e.write_valid)
                    report("write_valid", o_out.write_valid, e.write_valid);
                if (o_out.write_register !== e.write_register)
                    report("write_register", o_out.write_register, e.write_register);
                if (o_out.write_data !== e.write_data)
                    report("write_data", o_out.write_data, e.write_data);
                if (o_out.calibration_request !== e.calibration_request)
                    report("calibration_request", o_out.calibration_request,
                           e.calibration_request);
                if (o_out.last !== e.last) report("last", o_out.last, e.last);
            end
        end
    end

    // Receiver stalls
    always @(negedge i_clk) begin
        i_out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // Drive one input beat and hold it until accepted
    task automatic send_beat(mrs_pkg::t_in it);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        // Ready only moves at rising edges, so its value here holds at the next one
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        predict_beat(it);
        rand_items++;
    endtask

    task automatic send_op(logic [1:0] op, logic [7:0] b);
        mrs_pkg::t_in it;
        it.op = op;
        it.rx_byte = b;
        it.table_index = 6'($urandom_range(63));
        it.table_value = 16'($urandom);
        send_beat(it);
    endtask

    task automatic local_write(int idx, logic [15:0] v);
        mrs_pkg::t_in it;
        it.op = mrs_pkg::OP_LOCAL;
        it.rx_byte = 8'($urandom);
        it.table_index = 6'(idx);
        it.table_value = v;
        send_beat(it);
    endtask

    // Tick until the predicted gap timer stops
    task automatic close_frame();
        do send_op(mrs_pkg::OP_TICK, 8'($urandom)); while (gap_run || line_err);
    endtask

    // Send request bytes with CRC (optionally corrupted or with a line error), then close the frame
    task automatic send_frame(logic [7:0] req [$], bit bad_crc, bit line_fault);
        logic [15:0] crc;
        crc = 16'hffff;
        foreach (req[i]) crc = crc16_next(crc, req[i]);
        if (bad_crc) crc ^= 16'h0001 << $urandom_range(15);
        req.push_back(crc[7:0]);
        req.push_back(crc[15:8]);
        foreach (req[i]) begin
            if (line_fault && i == req.size() / 2) send_op(mrs_pkg::OP_ERROR, req[i]);
            else send_op(mrs_pkg::OP_BYTE, req[i]);
        end
        close_frame();
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (resp_q.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [7:0] v);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == mrs_pkg::CFG_GAP_LIMIT) begin
            gap_lim = v;
        end else begin
            slave_id = v;
        end
    endtask

    // Directed: read functions, count zero, range edges, short payload
    task automatic test_reads();
        local_write(0, 16'hffff);
        local_write(19, 16'h8001);
        local_write(20, 16'h1234);
        local_write(59, 16'hfedc);
        local_write(63, 16'h5555);
        send_frame({slave_id, mrs_pkg::FN_READ_HOLDING, 8'd0, 8'd0, 8'd0, 8'd20}, 0, 0);
        write_cfg(mrs_pkg::CFG_GAP_LIMIT, 8'd1);
        send_frame({slave_id, mrs_pkg::FN_READ_INPUT, 8'd0, 8'd39, 8'd0, 8'd1}, 0, 0);
        send_frame({slave_id, mrs_pkg::FN_READ_INPUT, 8'd0, 8'd0, 8'd0, 8'd0}, 0, 0);
        send_frame({slave_id, mrs_pkg::FN_READ_HOLDING, 8'd0, 8'd10, 8'd0, 8'd11}, 0, 0);
        send_frame({slave_id, mrs_pkg::FN_READ_INPUT, 8'hff, 8'hff, 8'hff, 8'hff}, 0, 0);
        send_frame({slave_id, mrs_pkg::FN_READ_HOLDING}, 0, 0);
    endtask

    // Directed: single and multiple writes, device ID, calibration registers, unknown function
    task automatic test_writes();
        send_frame({slave_id, mrs_pkg::FN_WRITE_MULTI, 8'd0, 8'd0, 8'd0, 8'd20, 8'd40,
                    8'hff, 8'h01, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc, 8'hde, 8'hf0,
                    8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88,
                    8'h99, 8'haa, 8'hbb, 8'hcc, 8'hdd, 8'hee, 8'hff, 8'hff}, 0, 0);
        send_frame({slave_id, mrs_pkg::FN_WRITE_MULTI, 8'd0, 8'd19, 8'd0, 8'd2, 8'd4}, 0, 0);
        send_frame({slave_id, mrs_pkg::FN_WRITE_SINGLE, 8'd0, 8'd9, 8'hab, 8'hcd}, 0, 0);
        send_frame({slave_id, mrs_pkg::FN_WRITE_SINGLE, 8'd0, 8'd20, 8'h00, 8'h01}, 0, 0);
        send_frame({slave_id, mrs_pkg::FN_READ_HOLDING, 8'd0, 8'd9, 8'd0, 8'd3}, 0, 0);
        send_frame({slave_id, mrs_pkg::FN_WRITE_SINGLE, 8'd0, 8'(mrs_pkg::REG_ID),
                    8'h77, 8'h2c}, 0, 0);
        send_frame({slave_id, 8'h2b, 8'd0, 8'd0}, 0, 0);
    endtask

    // Directed: dropped frames and short frames
    task automatic test_drops();
        send_frame({slave_id, mrs_pkg::FN_READ_HOLDING, 8'd0, 8'd0, 8'd0, 8'd1}, 1, 0);
        send_frame({slave_id, mrs_pkg::FN_READ_HOLDING, 8'd0, 8'd0, 8'd0, 8'd1}, 0, 1);
        send_frame({slave_id ^ 8'h01, mrs_pkg::FN_READ_HOLDING, 8'd0, 8'd0, 8'd0, 8'd1}, 0, 0);
        send_op(mrs_pkg::OP_BYTE, slave_id);
        send_op(mrs_pkg::OP_BYTE, 8'h00);
        close_frame();
    endtask

    // Directed: extreme register values
    task automatic test_config();
        write_cfg(mrs_pkg::CFG_SLAVE_ADDR, 8'd255);
        send_frame({8'd255, mrs_pkg::FN_READ_HOLDING, 8'd0, 8'd0, 8'd0, 8'd2}, 0, 0);
        write_cfg(mrs_pkg::CFG_GAP_LIMIT, 8'd1);
        write_cfg(mrs_pkg::CFG_SLAVE_ADDR, 8'd0);
        send_frame({8'd0, mrs_pkg::FN_WRITE_SINGLE, 8'd0, 8'd5, 8'h12, 8'h34}, 0, 0);
    endtask

    // Random requests, mostly well formed, mixed with noise and local writes
    task automatic test_random(int n_items);
        logic [7:0] req [$];
        int sel, start, cnt, lim;
        logic [7:0] fn;
        rand_items = 0;
        while (rand_items < n_items) begin
            sel = $urandom_range(99);
            if (sel < 15) begin
                local_write($urandom_range(63), 16'($urandom));
            end else if (sel < 20) begin
                send_op(2'($urandom_range(mrs_pkg::OP_TICK)), 8'($urandom));
            end else begin
                case ($urandom_range(4))
                    0: fn = mrs_pkg::FN_READ_HOLDING;
                    1: fn = mrs_pkg::FN_READ_INPUT;
                    2: fn = mrs_pkg::FN_WRITE_SINGLE;
                    3: fn = mrs_pkg::FN_WRITE_MULTI;
                    default: fn = 8'($urandom);
                endcase
                lim = (fn == mrs_pkg::FN_READ_INPUT) ? INPUT_N : HOLD_N;
                start = $urandom_range(lim);
                cnt = $urandom_range(lim - start + 1);
                if (fn == mrs_pkg::FN_WRITE_SINGLE) begin
                    start = ($urandom_range(4) == 0) ? int'(mrs_pkg::REG_ID)
                                                     : $urandom_range(HOLD_N + 1);
                    cnt = $urandom_range(16'hffff);
                end
                if ($urandom_range(15) == 0) start = $urandom_range(16'hffff);
                req = {($urandom_range(19) == 0) ? 8'($urandom) : slave_id, fn,
                       8'(start >> 8), 8'(start), 8'(cnt >> 8), 8'(cnt)};
                if (fn == mrs_pkg::FN_WRITE_MULTI) begin
                    req.push_back(8'(cnt * 2));
                    for (int i = 0; i < 2 * cnt && i < 2 * HOLD_N; i++)
                        req.push_back(8'($urandom));
                end
                if ($urandom_range(9) == 0) void'(req.pop_back());
                send_frame(req, $urandom_range(19) == 0, $urandom_range(19) == 0);
            end
        end
    endtask

    initial begin
        err_cnt = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        for (int i = 0; i < 256; i++) frm_buf[i] = 8'h00;
        for (int i = 0; i < TABLE_N; i++) reg_tab[i] = 16'h0000;
        frm_len = 0;
        gap_cnt = 0;
        gap_run = 0;
        line_err = 0;
        gap_lim = mrs_pkg::GAP_LIMIT_RST;
        slave_id = mrs_pkg::SLAVE_ADDR_RST;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reads();
        test_writes();
        test_drops();
        test_config();

        // Random phases under different flow control
        write_cfg(mrs_pkg::CFG_GAP_LIMIT, 8'd2);
        write_cfg(mrs_pkg::CFG_SLAVE_ADDR, 8'($urandom));
        test_random(15);
        send_idle_pct = 64;
        write_cfg(mrs_pkg::CFG_GAP_LIMIT, 8'($urandom_range(1, 4)));
        test_random(15);
        send_idle_pct = 0;
        stall_pct = 64;
        write_cfg(mrs_pkg::CFG_SLAVE_ADDR, 8'($urandom));
        test_random(15);
        send_idle_pct = 24;
        stall_pct = 24;
        write_cfg(mrs_pkg::CFG_GAP_LIMIT, 8'($urandom_range(1, 3)));
        test_random(15);

        wait_idle();
        if (resp_q.size() != 0) report("leftover beats", resp_q.size(), 0);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
